@@ design/peer_sequence_filter_keepalive_defines.svh @@
// assertion macros for the peer sequence filter
// used by psfk_table and peer_sequence_filter_keepalive
`ifndef PEER_SEQUENCE_FILTER_KEEPALIVE_DEFINES_SVH
`define PEER_SEQUENCE_FILTER_KEEPALIVE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSFK_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PSFK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PSFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSFK_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define PSFK_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PSFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/psfk_pkg.sv @@
// shared constants, codes and structs for the peer sequence filter
// no dependencies
`default_nettype none

package psfk_pkg;

  localparam int PEERS      = 16;
  localparam int SLOT_W     = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int ADDR_W     = 48;
  localparam int SEQ_W      = 16;
  localparam int MSG_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int QUIET_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [ADDR_W-1:0]  ADDR_BCAST = {ADDR_W{1'b1}};
  localparam logic [QUIET_W-1:0] QUIET_MAX  = {QUIET_W{1'b1}};

  localparam logic [QUIET_W-1:0] TIMEOUT_MS_RESET       = 20'd10000;
  localparam logic [SEQ_W-1:0]   WRAP_LAST_MIN_RESET    = 16'd200;
  localparam logic [SEQ_W-1:0]   WRAP_NEW_MAX_RESET     = 16'd50;
  localparam logic [SEQ_W-1:0]   RESTART_LAST_MIN_RESET = 16'd100;
  localparam logic [SEQ_W-1:0]   RESTART_SEQ_MAX_RESET  = 16'd1;

  localparam logic KIND_TICK = 1'b1;

  localparam logic [MSG_W-1:0] MSG_SPEED        = 3'd2;
  localparam logic [MSG_W-1:0] MSG_REGISTRATION = 3'd3;
  localparam logic [MSG_W-1:0] MSG_KEEPALIVE    = 3'd4;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_BAD_FRAME   = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_STALE       = 3'd3,
    ST_TICK_QUIET  = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT_MS       = 3'd0,
    REG_WRAP_LAST_MIN    = 3'd1,
    REG_WRAP_NEW_MAX     = 3'd2,
    REG_RESTART_LAST_MIN = 3'd3,
    REG_RESTART_SEQ_MAX  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [SEQ_W-1:0]  last_seq;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } tbl_lookup_t;

  typedef struct packed {
    logic              clear_all;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    logic              wr_addr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SEQ_W-1:0]  wr_seq;
  } tbl_write_t;

endpackage

`default_nettype wire

@@ design/psfk_if.sv @@
// valid/ready channel interfaces for items and results
// depends on psfk_pkg
`default_nettype none

interface psfk_item_if
  import psfk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] peer_address;
  logic              frame_ok;
  logic [MSG_W-1:0]  msg_type;
  logic [SEQ_W-1:0]  seq_number;
  logic [BYTE_W-1:0] payload_byte;

  modport source (
    output valid, kind, peer_address, frame_ok, msg_type, seq_number, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, peer_address, frame_ok, msg_type, seq_number, payload_byte,
    output ready
  );
endinterface

interface psfk_result_if
  import psfk_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [MSG_W-1:0]  message_type;
  logic [BYTE_W-1:0] payload_value;
  logic              is_registered;
  logic              new_peer;
  logic              table_full;

  modport source (
    output valid, status, message_type, payload_value, is_registered, new_peer, table_full,
    input  ready
  );
  modport sink (
    input  valid, status, message_type, payload_value, is_registered, new_peer, table_full,
    output ready
  );
endinterface

`default_nettype wire

@@ design/psfk_table.sv @@
// peer table: flop cam of addresses with last sequence per slot
// depends on psfk_pkg and the assertion macro header
`default_nettype none
`include "peer_sequence_filter_keepalive_defines.svh"

module psfk_table
  import psfk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] lookup_addr,
  input  wire tbl_write_t        wr,
  output tbl_lookup_t            look
);

  logic [PEERS-1:0]  slot_valid;
  logic [PEERS-1:0]  slot_valid_next;
  logic [ADDR_W-1:0] slot_address  [PEERS];
  logic [SEQ_W-1:0]  slot_last_seq [PEERS];
  logic [PEERS-1:0]  match;

  always_comb begin
    for (int i = 0; i < PEERS; i++) begin
      match[i] = slot_valid[i] && (slot_address[i] == lookup_addr);
    end
  end

  always_comb begin
    look.hit        = |match;
    look.hit_idx    = '0;
    look.free_found = ~&slot_valid;
    look.free_idx   = '0;
    for (int i = PEERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        look.hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        look.free_idx = SLOT_W'(i);
      end
    end
    look.last_seq = slot_last_seq[look.hit_idx];
  end

  always_comb begin
    slot_valid_next = slot_valid;
    if (wr.clear_all) begin
      slot_valid_next = '0;
    end
    if (wr.wr_en && wr.wr_addr_en) begin
      slot_valid_next[wr.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      slot_last_seq[wr.wr_idx] <= wr.wr_seq;
      if (wr.wr_addr_en) begin
        slot_address[wr.wr_idx] <= wr.wr_addr;
      end
    end
  end

  `PSFK_ASSERT_ALWAYS(a_single_match, clk, rst, $onehot0(match), "peer address in two slots")
  `PSFK_ASSERT_NEXT(a_clear_empties, clk, rst, wr.clear_all && !wr.wr_en, slot_valid == '0, "table not cleared")
  `PSFK_ASSERT_NEXT(a_insert_valid, clk, rst, wr.wr_en && wr.wr_addr_en, slot_valid[$past(wr.wr_idx)], "inserted slot not valid")

endmodule

`default_nettype wire

@@ design/peer_sequence_filter_keepalive.sv @@
// top level: receive filter with peer sequence table and keepalive timeout
// depends on psfk_pkg, psfk_if, psfk_table and the assertion macro header
//
//   channel   dir  handshake      contents
//   item      in   valid/ready    kind, peer_address, frame_ok, msg_type, seq_number,
//                                 payload_byte
//   result    out  valid/ready    status, message_type, payload_value, is_registered,
//                                 new_peer, table_full
//   write     in   write_en only  write_index, write_data (register file)
//
// one item per cycle sustained while the result side is ready; an item passes the input
// register, then table lookup and update into the result register
// synchronous reset clears the table valid bits, registered flag, quiet counter and
// loads the register defaults
// a stalled result holds the result register and then the input register
`default_nettype none
`include "peer_sequence_filter_keepalive_defines.svh"

module peer_sequence_filter_keepalive
  import psfk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  psfk_item_if.sink                  item,
  psfk_result_if.source              result,
  input  wire logic                  write_en,
  input  wire logic [CFG_IDX_W-1:0]  write_index,
  input  wire logic [CFG_DATA_W-1:0] write_data
);

  // configuration
  logic [QUIET_W-1:0] timeout_ms;
  logic [SEQ_W-1:0]   wrap_last_min;
  logic [SEQ_W-1:0]   wrap_new_max;
  logic [SEQ_W-1:0]   restart_last_min;
  logic [SEQ_W-1:0]   restart_seq_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms       <= TIMEOUT_MS_RESET;
      wrap_last_min    <= WRAP_LAST_MIN_RESET;
      wrap_new_max     <= WRAP_NEW_MAX_RESET;
      restart_last_min <= RESTART_LAST_MIN_RESET;
      restart_seq_max  <= RESTART_SEQ_MAX_RESET;
    end else if (write_en) begin
      unique case (reg_index_t'(write_index))
        REG_TIMEOUT_MS:       timeout_ms       <= write_data[QUIET_W-1:0];
        REG_WRAP_LAST_MIN:    wrap_last_min    <= write_data[SEQ_W-1:0];
        REG_WRAP_NEW_MAX:     wrap_new_max     <= write_data[SEQ_W-1:0];
        REG_RESTART_LAST_MIN: restart_last_min <= write_data[SEQ_W-1:0];
        REG_RESTART_SEQ_MAX:  restart_seq_max  <= write_data[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid;
  logic              s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_ok;
  logic [MSG_W-1:0]  s1_type;
  logic [SEQ_W-1:0]  s1_seq;
  logic [BYTE_W-1:0] s1_payload;

  logic out_valid;
  logic adv;
  logic go;
  logic take;

  assign adv        = !out_valid || result.ready;
  assign go         = s1_valid && adv;
  assign item.ready = !s1_valid || adv;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind    <= item.kind;
      s1_addr    <= item.peer_address;
      s1_ok      <= item.frame_ok;
      s1_type    <= item.msg_type;
      s1_seq     <= item.seq_number;
      s1_payload <= item.payload_byte;
    end
  end

  // link state
  logic               registered;
  logic               registered_next;
  logic [QUIET_W-1:0] quiet_ms;
  logic [QUIET_W-1:0] quiet_ms_next;
  logic [QUIET_W-1:0] quiet_inc;

  tbl_lookup_t look;
  tbl_write_t  tw;
  tbl_write_t  wr;

  psfk_table u_table (
    .clk         (clk),
    .rst         (rst),
    .lookup_addr (s1_addr),
    .wr          (wr),
    .look        (look)
  );

  status_t           st;
  logic [MSG_W-1:0]  mtype;
  logic [BYTE_W-1:0] pval;
  logic              newp;
  logic              full;
  logic              accept;
  logic              seq_newer;

  assign quiet_inc = (quiet_ms == QUIET_MAX) ? quiet_ms : QUIET_W'(quiet_ms + 1'b1);

  assign seq_newer = (s1_seq > look.last_seq)
                  || (look.last_seq > wrap_last_min && s1_seq < wrap_new_max)
                  || (s1_seq <= restart_seq_max && look.last_seq > restart_last_min);

  always_comb begin
    st              = ST_ACCEPTED;
    mtype           = '0;
    pval            = '0;
    newp            = 1'b0;
    full            = 1'b0;
    accept          = 1'b1;
    tw              = '0;
    tw.wr_addr      = s1_addr;
    registered_next = registered;
    quiet_ms_next   = quiet_ms;
    priority if (s1_kind == KIND_TICK) begin
      quiet_ms_next = quiet_inc;
      if (registered && quiet_inc > timeout_ms) begin
        registered_next = 1'b0;
        tw.clear_all    = 1'b1;
        st              = ST_TIMEOUT;
      end else begin
        st = ST_TICK_QUIET;
      end
    end else if (s1_type > MSG_KEEPALIVE) begin
      st = ST_UNSUPPORTED;
    end else if (!s1_ok) begin
      st = ST_BAD_FRAME;
    end else begin
      newp = !look.hit;
      priority if (s1_type == MSG_REGISTRATION) begin
        tw.wr_seq = '0;
        priority if (!registered) begin
          // table restarts, peer lands in the first slot
          tw.clear_all  = 1'b1;
          tw.wr_en      = 1'b1;
          tw.wr_idx     = '0;
          tw.wr_addr_en = 1'b1;
        end else if (look.hit) begin
          tw.wr_en  = 1'b1;
          tw.wr_idx = look.hit_idx;
        end else if (look.free_found) begin
          tw.wr_en      = 1'b1;
          tw.wr_idx     = look.free_idx;
          tw.wr_addr_en = 1'b1;
        end else begin
          full = 1'b1;
        end
      end else if (!look.hit) begin
        tw.wr_seq = s1_seq;
        if (look.free_found) begin
          tw.wr_en      = 1'b1;
          tw.wr_idx     = look.free_idx;
          tw.wr_addr_en = 1'b1;
        end else begin
          full = 1'b1;
        end
      end else begin
        tw.wr_seq = s1_seq;
        tw.wr_idx = look.hit_idx;
        if (seq_newer) begin
          tw.wr_en = 1'b1;
        end else begin
          accept = 1'b0;
        end
      end
      if (!accept) begin
        st = ST_STALE;
      end else begin
        st    = ST_ACCEPTED;
        mtype = s1_type;
        if (s1_type <= MSG_SPEED) begin
          pval = s1_payload;
        end
        if (s1_type == MSG_REGISTRATION || s1_type == MSG_KEEPALIVE
            || s1_addr != ADDR_BCAST) begin
          registered_next = 1'b1;
          quiet_ms_next   = '0;
        end
      end
    end
  end

  always_comb begin
    wr = tw;
    if (!go) begin
      wr.clear_all = 1'b0;
      wr.wr_en     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= 1'b0;
      quiet_ms   <= '0;
    end else if (go) begin
      registered <= registered_next;
      quiet_ms   <= quiet_ms_next;
    end
  end

  // result register
  logic [2:0]        out_status;
  logic [MSG_W-1:0]  out_mtype;
  logic [BYTE_W-1:0] out_pval;
  logic              out_reg;
  logic              out_newp;
  logic              out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status <= st;
      out_mtype  <= mtype;
      out_pval   <= pval;
      out_reg    <= registered_next;
      out_newp   <= newp;
      out_full   <= full;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.message_type  = out_mtype;
  assign result.payload_value = out_pval;
  assign result.is_registered = out_reg;
  assign result.new_peer      = out_newp;
  assign result.table_full    = out_full;

  `PSFK_ASSERT_NEXT(a_tick_status, clk, rst, go && s1_kind == KIND_TICK,
    out_status == ST_TICK_QUIET || out_status == ST_TIMEOUT, "tick gave frame status")
  `PSFK_ASSERT_IMPL(a_timeout_drops, clk, rst, out_valid && out_status == ST_TIMEOUT,
    !out_reg, "timeout left link registered")
  `PSFK_ASSERT_NEXT(a_reg_renews, clk, rst,
    go && s1_kind != KIND_TICK && st == ST_ACCEPTED && s1_type == MSG_REGISTRATION,
    registered && quiet_ms == '0, "registration did not renew link")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for peer_sequence_filter_keepalive: directed frames and ticks, then random
// traffic over several register settings, checked against an in-bench link state predictor
// depends on psfk_pkg, psfk_if and the block's rtl

import psfk_pkg::*;

typedef struct packed {
  logic              kind;
  logic [ADDR_W-1:0] addr;
  logic              ok;
  logic [MSG_W-1:0]  mtype;
  logic [SEQ_W-1:0]  seq;
  logic [BYTE_W-1:0] payload;
} rx_frame_t;

typedef struct packed {
  status_t           status;
  logic [MSG_W-1:0]  message_type;
  logic [BYTE_W-1:0] payload_value;
  logic              is_registered;
  logic              new_peer;
  logic              table_full;
} filter_verdict_t;

typedef logic [CFG_DATA_W-1:0] reg_image_t [5];

class peer_filter_scoreboard;
  logic               slot_used [PEERS];
  logic [ADDR_W-1:0]  slot_addr [PEERS];
  logic [SEQ_W-1:0]   slot_seq  [PEERS];
  logic               linked;
  logic [QUIET_W-1:0] quiet;
  logic [QUIET_W-1:0] timeout_ms;
  logic [SEQ_W-1:0]   wrap_last_min;
  logic [SEQ_W-1:0]   wrap_new_max;
  logic [SEQ_W-1:0]   restart_last_min;
  logic [SEQ_W-1:0]   restart_seq_max;
  filter_verdict_t    awaited [$];
  int                 mismatches;
  int                 checked;
  int                 tally [8];
  int                 new_peers;
  int                 untracked;

  function new();
    forget_peers();
    foreach (slot_addr[i]) begin
      slot_addr[i] = '0;
      slot_seq[i]  = '0;
    end
    linked           = 1'b0;
    quiet            = '0;
    timeout_ms       = TIMEOUT_MS_RESET;
    wrap_last_min    = WRAP_LAST_MIN_RESET;
    wrap_new_max     = WRAP_NEW_MAX_RESET;
    restart_last_min = RESTART_LAST_MIN_RESET;
    restart_seq_max  = RESTART_SEQ_MAX_RESET;
  endfunction

  function void forget_peers();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  function int claim(logic [ADDR_W-1:0] addr);
    foreach (slot_used[i]) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_addr[i] = addr;
        return i;
      end
    end
    return -1;
  endfunction

  function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TIMEOUT_MS:       timeout_ms       = val;
      REG_WRAP_LAST_MIN:    wrap_last_min    = val[SEQ_W-1:0];
      REG_WRAP_NEW_MAX:     wrap_new_max     = val[SEQ_W-1:0];
      REG_RESTART_LAST_MIN: restart_last_min = val[SEQ_W-1:0];
      REG_RESTART_SEQ_MAX:  restart_seq_max  = val[SEQ_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // one transfer in, one verdict expected
  function void note_item(rx_frame_t it);
    filter_verdict_t v;
    int              hit;
    logic            take;
    v = '0;
    v.status = ST_ACCEPTED;
    take = 1'b1;
    if (it.kind == KIND_TICK) begin
      if (quiet != QUIET_MAX) quiet++;
      if (linked && quiet > timeout_ms) begin
        linked = 1'b0;
        forget_peers();
        v.status = ST_TIMEOUT;
      end else begin
        v.status = ST_TICK_QUIET;
      end
    end else if (it.mtype > MSG_KEEPALIVE) begin
      v.status = ST_UNSUPPORTED;
    end else if (!it.ok) begin
      v.status = ST_BAD_FRAME;
    end else begin
      hit = -1;
      foreach (slot_used[i])
        if (hit < 0 && slot_used[i] && slot_addr[i] == it.addr) hit = i;
      v.new_peer = (hit < 0);
      if (it.mtype == MSG_REGISTRATION) begin
        if (!linked) begin
          forget_peers();
          hit = -1;
        end
        if (hit < 0) begin
          hit = claim(it.addr);
          if (hit < 0) v.table_full = 1'b1;
        end
        if (hit >= 0) slot_seq[hit] = '0;
      end else if (hit < 0) begin
        hit = claim(it.addr);
        if (hit >= 0) slot_seq[hit] = it.seq;
        else v.table_full = 1'b1;
      end else if (it.seq > slot_seq[hit] ||
                   (slot_seq[hit] > wrap_last_min && it.seq < wrap_new_max) ||
                   (it.seq <= restart_seq_max && slot_seq[hit] > restart_last_min)) begin
        slot_seq[hit] = it.seq;
      end else begin
        take = 1'b0;
      end
      if (!take) begin
        v.status = ST_STALE;
      end else begin
        v.message_type = it.mtype;
        if (it.mtype <= MSG_SPEED) v.payload_value = it.payload;
        if (it.mtype == MSG_REGISTRATION || it.mtype == MSG_KEEPALIVE || it.addr != ADDR_BCAST) begin
          linked = 1'b1;
          quiet  = '0;
        end
      end
    end
    v.is_registered = linked;
    tally[v.status]++;
    if (v.new_peer) new_peers++;
    if (v.table_full) untracked++;
    awaited.push_back(v);
  endfunction

  function void check_result(filter_verdict_t got);
    filter_verdict_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with nothing pending: status %0d type %0d value %0h",
                 got.status, got.message_type, got.payload_value);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.status !== want.status || got.message_type !== want.message_type ||
        got.payload_value !== want.payload_value || got.is_registered !== want.is_registered ||
        got.new_peer !== want.new_peer || got.table_full !== want.table_full) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d: want st %0d ty %0d val %0h reg %0b new %0b full %0b",
                 checked, want.status, want.message_type, want.payload_value,
                 want.is_registered, want.new_peer, want.table_full,
                 "; got st %0d ty %0d val %0h reg %0b new %0b full %0b",
                 got.status, got.message_type, got.payload_value,
                 got.is_registered, got.new_peer, got.table_full);
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT_CYCLES = 200000;
  localparam int POOL = 24;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic [MSG_W-1:0] MSG_PATTERN    = 3'd0;
  localparam logic [MSG_W-1:0] MSG_BRIGHTNESS = 3'd1;
  localparam logic [MSG_W-1:0] MSG_UNSUP_LO   = 3'd5;
  localparam logic [MSG_W-1:0] MSG_UNSUP_HI   = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_en;
  logic [CFG_IDX_W-1:0]  write_index;
  logic [CFG_DATA_W-1:0] write_data;

  psfk_item_if   item_ch ();
  psfk_result_if result_ch ();

  peer_filter_scoreboard sb = new();

  logic [ADDR_W-1:0] peer_pool [POOL];
  logic [SEQ_W-1:0]  pool_seq  [POOL];
  int                source_idle_max = 0;
  int                sink_idle_max   = 0;
  int                hold_cycles     = 0;
  int                items_sent      = 0;

  peer_sequence_filter_keepalive i_dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("tb: failure");
    $finish;
  end

  function automatic rx_frame_t frame(logic kind, logic [ADDR_W-1:0] addr, logic ok,
                                      logic [MSG_W-1:0] mt, logic [SEQ_W-1:0] seq,
                                      logic [BYTE_W-1:0] payload);
    rx_frame_t it;
    it.kind    = kind;
    it.addr    = addr;
    it.ok      = ok;
    it.mtype   = mt;
    it.seq     = seq;
    it.payload = payload;
    return it;
  endfunction

  function automatic rx_frame_t noise_item();
    rx_frame_t it;
    it.kind    = 1'($urandom_range(0, 1));
    it.addr    = ADDR_W'({$urandom(), $urandom()});
    it.ok      = 1'($urandom_range(0, 1));
    it.mtype   = MSG_W'($urandom_range(0, 7));
    it.seq     = SEQ_W'($urandom());
    it.payload = BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  // well-formed frame from a pool peer, sequence mostly moving forward
  function automatic rx_frame_t frame_from(int who, logic [MSG_W-1:0] mt);
    rx_frame_t it;
    int        mode;
    mode     = $urandom_range(0, 99);
    it       = noise_item();
    it.kind  = KIND_FRAME;
    it.ok    = 1'b1;
    it.mtype = mt;
    it.addr  = peer_pool[who];
    if (mode < 55)      it.seq = pool_seq[who] + SEQ_W'($urandom_range(1, 40));
    else if (mode < 65) it.seq = pool_seq[who] - SEQ_W'($urandom_range(0, 20));
    else if (mode < 75) it.seq = SEQ_W'($urandom_range(0, 3));
    else if (mode < 85) it.seq = SEQ_W'($urandom_range(0, 60));
    pool_seq[who] = it.seq;
    return it;
  endfunction

  task automatic send_item(rx_frame_t it);
    int gap;
    gap = $urandom_range(0, source_idle_max);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= it.kind;
    item_ch.peer_address <= it.addr;
    item_ch.frame_ok     <= it.ok;
    item_ch.msg_type     <= it.mtype;
    item_ch.seq_number   <= it.seq;
    item_ch.payload_byte <= it.payload;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(reg_image_t image);
    reg_index_t r;
    r = r.first();
    write_en <= 1'b1;
    repeat (r.num()) begin
      write_index <= r;
      write_data  <= image[r];
      sb.set_reg(r, image[r]);
      @(negedge clk);
      r = r.next();
    end
    write_en <= 1'b0;
  endtask

  // result side
  initial begin
    filter_verdict_t got;
    int              wait_n;
    result_ch.ready <= 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_n = $urandom_range(0, sink_idle_max);
      end
      if (wait_n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready));
      got.status        = status_t'(result_ch.status);
      got.message_type  = result_ch.message_type;
      got.payload_value = result_ch.payload_value;
      got.is_registered = result_ch.is_registered;
      got.new_peer      = result_ch.new_peer;
      got.table_full    = result_ch.table_full;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    reg_image_t        image;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    int                phase_goal;
    int                span;
    int                roll;
    int                n;
    item_ch.valid        <= 1'b0;
    item_ch.kind         <= KIND_FRAME;
    item_ch.peer_address <= '0;
    item_ch.frame_ok     <= 1'b0;
    item_ch.msg_type     <= MSG_PATTERN;
    item_ch.seq_number   <= '0;
    item_ch.payload_byte <= '0;
    write_en             <= 1'b0;
    write_index          <= REG_TIMEOUT_MS;
    write_data           <= '0;

    peer_pool[0] = ADDR_BCAST;
    peer_pool[1] = '0;
    peer_pool[2] = 48'hAAAA_AAAA_AAAA;
    peer_pool[3] = 48'h5555_5555_5555;
    for (int i = 4; i < POOL; i++) peer_pool[i] = ADDR_W'({$urandom(), $urandom()});
    foreach (pool_seq[i]) pool_seq[i] = '0;
    a = peer_pool[5];
    b = peer_pool[6];

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset register values
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_UNSUP_LO, 16'd3, 8'h11));
    send_item(frame(KIND_FRAME, a, 1'b0, MSG_UNSUP_HI, 16'd3, 8'h11));
    send_item(frame(KIND_FRAME, a, 1'b0, MSG_PATTERN, 16'd3, 8'h11));
    send_item(frame(KIND_TICK, '0, 1'b0, MSG_PATTERN, 16'd0, 8'h00));
    // broadcast data before any registration does not bring the link up
    send_item(frame(KIND_FRAME, ADDR_BCAST, 1'b1, MSG_PATTERN, 16'd5, 8'hFF));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_REGISTRATION, 16'hFFFF, 8'h22));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_PATTERN, 16'd10, 8'h00));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_BRIGHTNESS, 16'd10, 8'h33));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_SPEED, 16'd300, 8'hA5));
    // wrap past the thresholds
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_SPEED, 16'd20, 8'h5A));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_PATTERN, 16'd150, 8'h01));
    // sender restart
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_PATTERN, 16'd1, 8'h80));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_KEEPALIVE, 16'd0, 8'h44));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_KEEPALIVE, 16'hFFFF, 8'h44));
    send_item(frame(KIND_FRAME, a, 1'b1, MSG_PATTERN, 16'd0, 8'h7F));
    send_item(frame(KIND_FRAME, ADDR_BCAST, 1'b1, MSG_BRIGHTNESS, 16'd3, 8'hC3));
    send_item(frame(KIND_FRAME, b, 1'b1, MSG_REGISTRATION, 16'd9, 8'h00));
    send_item(frame(KIND_FRAME, b, 1'b1, MSG_KEEPALIVE, 16'd0, 8'h00));
    send_item(frame(KIND_TICK, ADDR_BCAST, 1'b1, MSG_UNSUP_HI, 16'hFFFF, 8'hFF));
    send_item(frame(KIND_FRAME, a, 1'b1, 3'd6, 16'd400, 8'h00));
    send_item(frame(KIND_FRAME, a, 1'b0, MSG_REGISTRATION, 16'd400, 8'h00));
    send_item(frame(KIND_FRAME, peer_pool[1], 1'b1, MSG_SPEED, 16'd0, 8'h5A));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      source_idle_max = (phase % 3 == 0) ? 0 : 13;
      sink_idle_max   = (phase % 4 == 1) ? 0 : 13;
      span            = (phase % 2 == 1) ? POOL : 7;
      case (phase)
        0: begin
          image[REG_TIMEOUT_MS]       = 20'd1;
          image[REG_WRAP_LAST_MIN]    = '0;
          image[REG_WRAP_NEW_MAX]     = '0;
          image[REG_RESTART_LAST_MIN] = '0;
          image[REG_RESTART_SEQ_MAX]  = '0;
        end
        1: begin
          image[REG_TIMEOUT_MS]       = 20'd1000000;
          image[REG_WRAP_LAST_MIN]    = 20'd65535;
          image[REG_WRAP_NEW_MAX]     = 20'd65535;
          image[REG_RESTART_LAST_MIN] = 20'd65535;
          image[REG_RESTART_SEQ_MAX]  = 20'd65535;
        end
        2: begin
          image[REG_TIMEOUT_MS]       = 20'd5;
          image[REG_WRAP_LAST_MIN]    = WRAP_LAST_MIN_RESET;
          image[REG_WRAP_NEW_MAX]     = WRAP_NEW_MAX_RESET;
          image[REG_RESTART_LAST_MIN] = RESTART_LAST_MIN_RESET;
          image[REG_RESTART_SEQ_MAX]  = RESTART_SEQ_MAX_RESET;
        end
        default: begin
          image[REG_TIMEOUT_MS] = CFG_DATA_W'($urandom_range(1, 30));
          for (int r = 1; r < 5; r++)
            image[r] = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 400))
                                            : CFG_DATA_W'($urandom_range(0, 65535));
        end
      endcase
      apply_settings(image);
      // long result stall while the sender keeps offering
      if (phase == 3 || phase == 6) hold_cycles = 300;
      phase_goal = items_sent + 106;
      while (items_sent < phase_goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          n = $urandom_range(1, 24);
          repeat (n) begin
            rx_frame_t t;
            t = noise_item();
            t.kind = KIND_TICK;
            send_item(t);
          end
        end else if (roll < 10) begin
          rx_frame_t t;
          t = noise_item();
          t.kind = KIND_TICK;
          send_item(t);
        end else if (roll < 14) begin
          rx_frame_t t;
          t = noise_item();
          t.kind  = KIND_FRAME;
          t.mtype = MSG_W'($urandom_range(MSG_UNSUP_LO, MSG_UNSUP_HI));
          send_item(t);
        end else if (roll < 18) begin
          rx_frame_t t;
          t = frame_from($urandom_range(0, span - 1), MSG_W'($urandom_range(0, MSG_KEEPALIVE)));
          t.ok = 1'b0;
          send_item(t);
        end else if (roll < 21) begin
          // walk the pool past its first entry so the table fills up
          for (int w = 1; w < POOL; w++)
            send_item(frame_from(w, MSG_W'($urandom_range(MSG_PATTERN, MSG_SPEED))));
        end else if (roll < 31) begin
          send_item(frame_from($urandom_range(0, span - 1), MSG_REGISTRATION));
        end else if (roll < 43) begin
          send_item(frame_from($urandom_range(0, span - 1), MSG_KEEPALIVE));
        end else begin
          send_item(frame_from($urandom_range(0, span - 1),
                               MSG_W'($urandom_range(MSG_PATTERN, MSG_SPEED))));
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run: %0d frames and ticks over 8 register settings, %0d results checked",
             items_sent, sb.checked);
    $display("run: %0d accepted %0d stale %0d bad %0d unsupported %0d quiet %0d timeout, %0d new %0d untracked",
             sb.tally[ST_ACCEPTED], sb.tally[ST_STALE], sb.tally[ST_BAD_FRAME],
             sb.tally[ST_UNSUPPORTED], sb.tally[ST_TICK_QUIET], sb.tally[ST_TIMEOUT],
             sb.new_peers, sb.untracked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
